FILE: sv/rrva_pkg.sv
package rrva_pkg;

  localparam int NUM_PORTS = 3;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_ARB   = 2'd2;

  localparam logic [1:0] PORT_LOCAL   = 2'd0;
  localparam logic [1:0] PORT_LEFT    = 2'd1;
  localparam logic [1:0] PORT_RIGHT   = 2'd2;
  localparam logic [1:0] PORT_INVALID = 2'd3;

  localparam logic [1:0] DIR_NONE   = 2'd0;
  localparam logic [1:0] DIR_UNUSED = 2'd3;

  localparam logic [2:0] ADDR_ROUTER_ID = 3'd0;
  localparam logic [2:0] ADDR_RING_SIZE = 3'd4;

  localparam logic [5:0] ROUTER_ID_RST = 6'd0;
  localparam logic [6:0] RING_SIZE_RST = 7'd4;

  typedef logic [47:0] age_t;
  typedef logic [5:0]  dest_t;

endpackage

FILE: sv/ring_router_route_and_vc_alloc.sv
// Ring router slot table with route computation and oldest-first VC allocation.
// Input channel (in_valid/in_ready): one request per transfer. A load stores a
// flit in slot (in_port, in_vc) and, for a ready head that is not route-fixed,
// computes the output port. A clear empties a slot. An arbitrate request scans
// all slots for the oldest routed head flit from another port that wants the
// requested output port and VC.
// Result channel (out_valid/out_ready): exactly one result transfer per request.
// A load, clear or unknown request goes from S_IDLE straight to S_DONE; an
// arbitrate request first passes through S_SCAN, where the single age
// comparator visits one slot per cycle, and then reaches S_DONE. From S_DONE
// the result is registered in the output register.
// The block takes one request at a time; it accepts the next request as soon
// as the previous one is finished, even while that result still waits in the
// output register. A stalled receiver holds the result and, once the next
// request is done, holds that request until the output register frees up.
// Configuration (router_id at 0x0, ring_size at 0x4) is to be written through
// the APB-style port only while the block is idle; the block does not enforce it.
// Reset clears every slot's valid, head, routed and route bits, sets router_id
// to 0 and ring_size to 4.
module ring_router_route_and_vc_alloc
  import rrva_pkg::*;
#(
  parameter int NUM_VCS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [1:0]  in_in_port,
  input  logic [1:0]  in_in_vc,
  input  logic [5:0]  in_flit_dst,
  input  logic [1:0]  in_flit_dir,
  input  logic [47:0] in_flit_time,
  input  logic        in_is_head,
  input  logic        in_flit_ready,
  input  logic        in_route_fixed,
  input  logic [1:0]  in_out_port,
  input  logic [1:0]  in_out_vc,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_route_done,
  output logic [1:0]  out_route_port,
  output logic [1:0]  out_new_dir,
  output logic        out_winner_found,
  output logic [1:0]  out_winner_port,
  output logic [1:0]  out_winner_vc,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int VC_W = (NUM_VCS > 1) ? $clog2(NUM_VCS) : 1;
  localparam logic [VC_W-1:0] LAST_VC = VC_W'(NUM_VCS - 1);
  localparam logic [1:0] LAST_PORT = 2'(NUM_PORTS - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_r, state_nxt;

  logic [5:0] router_id_r;
  logic [6:0] ring_size_r;

  logic       slot_valid_r  [NUM_PORTS][NUM_VCS];
  logic       slot_head_r   [NUM_PORTS][NUM_VCS];
  logic       slot_routed_r [NUM_PORTS][NUM_VCS];
  logic [2:0] slot_mask_r   [NUM_PORTS][NUM_VCS];
  dest_t      slot_dest_r   [NUM_PORTS][NUM_VCS];
  age_t       slot_age_r    [NUM_PORTS][NUM_VCS];

  logic [1:0]      scan_port_r;
  logic [VC_W-1:0] scan_vc_r;
  logic [1:0]      arb_port_r;
  logic [1:0]      arb_vc_r;
  logic            found_r;
  age_t            best_age_r;
  logic [1:0]      win_port_r;
  logic [VC_W-1:0] win_vc_r;

  logic       res_route_done_r;
  logic [1:0] res_route_port_r;
  logic [1:0] res_new_dir_r;

  logic            out_valid_r;
  logic            o_route_done_r;
  logic [1:0]      o_route_port_r;
  logic [1:0]      o_new_dir_r;
  logic            o_winner_found_r;
  logic [1:0]      o_winner_port_r;
  logic [1:0]      o_winner_vc_r;

  logic            in_fire;
  logic            cfg_wr;
  logic            slot_ok;
  logic [VC_W-1:0] ld_vc;
  logic            do_route;
  logic [1:0]      dir_eff;
  logic [1:0]      rt_port;
  logic [1:0]      rt_dir;
  logic signed [8:0] id_s, dst_s, n_s, left_s, right_s;
  logic            cand;
  logic            duato_ok;
  logic            scan_last;
  logic            out_free;

  assign in_ready   = (state_r == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr == ADDR_RING_SIZE) ? {25'd0, ring_size_r}
                                                    : {26'd0, router_id_r};

  assign slot_ok  = ({1'b0, in_in_port} < 3'(NUM_PORTS)) && (int'(in_in_vc) < NUM_VCS);
  assign ld_vc    = VC_W'(in_in_vc);
  assign do_route = in_is_head && in_flit_ready && !in_route_fixed;
  assign dir_eff  = (in_flit_dir == DIR_UNUSED) ? DIR_NONE : in_flit_dir;

  always_comb begin
    id_s  = signed'({3'b000, router_id_r});
    dst_s = signed'({3'b000, in_flit_dst});
    n_s   = signed'({2'b00, ring_size_r});
    if (id_s > dst_s) begin
      left_s  = id_s - dst_s;
      right_s = dst_s - id_s + n_s;
    end else begin
      left_s  = id_s - dst_s + n_s;
      right_s = dst_s - id_s;
    end
    if (in_flit_dst == router_id_r) begin
      rt_port = PORT_LOCAL;
      rt_dir  = dir_eff;
    end else if (dir_eff != DIR_NONE) begin
      rt_port = dir_eff;
      rt_dir  = dir_eff;
    end else begin
      rt_port = (left_s < right_s) ? PORT_LEFT : PORT_RIGHT;
      rt_dir  = rt_port;
    end
  end

  always_comb begin
    duato_ok = 1'b1;
    if (int'(arb_vc_r) == NUM_VCS - 2 &&
        router_id_r > slot_dest_r[scan_port_r][scan_vc_r]) begin
      duato_ok = 1'b0;
    end
    if (int'(arb_vc_r) == NUM_VCS - 1 &&
        router_id_r < slot_dest_r[scan_port_r][scan_vc_r]) begin
      duato_ok = 1'b0;
    end
    cand = (scan_port_r != arb_port_r) && (arb_port_r != PORT_INVALID) &&
           slot_valid_r[scan_port_r][scan_vc_r] &&
           slot_mask_r[scan_port_r][scan_vc_r][arb_port_r] &&
           slot_head_r[scan_port_r][scan_vc_r] &&
           slot_routed_r[scan_port_r][scan_vc_r] && duato_ok &&
           (!found_r || slot_age_r[scan_port_r][scan_vc_r] < best_age_r);
  end

  assign scan_last = (scan_port_r == LAST_PORT) && (scan_vc_r == LAST_VC);
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_req_type == REQ_ARB) ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      router_id_r <= ROUTER_ID_RST;
      ring_size_r <= RING_SIZE_RST;
      out_valid_r <= 1'b0;
      for (int p = 0; p < NUM_PORTS; p++) begin
        for (int v = 0; v < NUM_VCS; v++) begin
          slot_valid_r[p][v]  <= 1'b0;
          slot_head_r[p][v]   <= 1'b0;
          slot_routed_r[p][v] <= 1'b0;
          slot_mask_r[p][v]   <= 3'b000;
        end
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        if (cfg_paddr == ADDR_RING_SIZE) begin
          ring_size_r <= cfg_pwdata[6:0];
        end else if (cfg_paddr == ADDR_ROUTER_ID) begin
          router_id_r <= cfg_pwdata[5:0];
        end
      end
      if (in_fire && slot_ok) begin
        if (in_req_type == REQ_LOAD) begin
          slot_valid_r[in_in_port][ld_vc]  <= 1'b1;
          slot_head_r[in_in_port][ld_vc]   <= in_is_head;
          slot_routed_r[in_in_port][ld_vc] <= do_route;
          if (do_route) begin
            slot_mask_r[in_in_port][ld_vc] <= 3'b001 << rt_port;
          end
        end else if (in_req_type == REQ_CLEAR) begin
          slot_valid_r[in_in_port][ld_vc]  <= 1'b0;
          slot_head_r[in_in_port][ld_vc]   <= 1'b0;
          slot_routed_r[in_in_port][ld_vc] <= 1'b0;
          slot_mask_r[in_in_port][ld_vc]   <= 3'b000;
        end
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && slot_ok && in_req_type == REQ_LOAD) begin
      slot_dest_r[in_in_port][ld_vc] <= in_flit_dst;
      slot_age_r[in_in_port][ld_vc]  <= in_flit_time;
    end
    if (in_fire) begin
      arb_port_r       <= in_out_port;
      arb_vc_r         <= in_out_vc;
      scan_port_r      <= 2'd0;
      scan_vc_r        <= '0;
      found_r          <= 1'b0;
      best_age_r       <= '0;
      win_port_r       <= 2'd0;
      win_vc_r         <= '0;
      res_route_done_r <= 1'b0;
      res_route_port_r <= 2'd0;
      res_new_dir_r    <= 2'd0;
      if (in_req_type == REQ_LOAD && slot_ok && do_route) begin
        res_route_done_r <= 1'b1;
        res_route_port_r <= rt_port;
        res_new_dir_r    <= rt_dir;
      end
    end else if (state_r == S_SCAN) begin
      if (cand) begin
        found_r    <= 1'b1;
        best_age_r <= slot_age_r[scan_port_r][scan_vc_r];
        win_port_r <= scan_port_r;
        win_vc_r   <= scan_vc_r;
      end
      if (scan_vc_r == LAST_VC) begin
        scan_vc_r   <= '0;
        scan_port_r <= scan_port_r + 2'd1;
      end else begin
        scan_vc_r <= scan_vc_r + VC_W'(1);
      end
    end
    if (state_r == S_DONE && out_free) begin
      o_route_done_r   <= res_route_done_r;
      o_route_port_r   <= res_route_port_r;
      o_new_dir_r      <= res_new_dir_r;
      o_winner_found_r <= found_r;
      o_winner_port_r  <= win_port_r;
      o_winner_vc_r    <= 2'(win_vc_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_route_done   = o_route_done_r;
  assign out_route_port   = o_route_port_r;
  assign out_new_dir      = o_new_dir_r;
  assign out_winner_found = o_winner_found_r;
  assign out_winner_port  = o_winner_port_r;
  assign out_winner_vc    = o_winner_vc_r;

endmodule

FILE: tb/route_alloc_monitor.sv
module route_alloc_monitor
  import rrva_pkg::*;
#(
  parameter int NUM_VCS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [1:0]  in_in_port,
  input  logic [1:0]  in_in_vc,
  input  logic [5:0]  in_flit_dst,
  input  logic [1:0]  in_flit_dir,
  input  logic [47:0] in_flit_time,
  input  logic        in_is_head,
  input  logic        in_flit_ready,
  input  logic        in_route_fixed,
  input  logic [1:0]  in_out_port,
  input  logic [1:0]  in_out_vc,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_route_done,
  input  logic [1:0]  out_route_port,
  input  logic [1:0]  out_new_dir,
  input  logic        out_winner_found,
  input  logic [1:0]  out_winner_port,
  input  logic [1:0]  out_winner_vc,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          mismatch_count,
  output int          replies_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SLOTS = NUM_PORTS * NUM_VCS;

  typedef struct packed {
    logic       route_done;
    logic [1:0] route_port;
    logic [1:0] new_dir;
    logic       winner_found;
    logic [1:0] winner_port;
    logic [1:0] winner_vc;
  } reply_t;

  logic       slot_valid  [NUM_SLOTS];
  logic       slot_head   [NUM_SLOTS];
  logic       slot_routed [NUM_SLOTS];
  logic [2:0] slot_mask   [NUM_SLOTS];
  dest_t      slot_dest   [NUM_SLOTS];
  age_t       slot_age    [NUM_SLOTS];
  logic [5:0] router_id;
  logic [6:0] ring_size;
  reply_t     awaited_replies [$];

  function automatic reply_t serve_request(
    logic [1:0] req, logic [1:0] port, logic [1:0] vc, dest_t dst, logic [1:0] dir,
    age_t stamp, logic head, logic rdy, logic fixed, logic [1:0] op, logic [1:0] ov);
    reply_t r;
    int s;
    int i;
    int left;
    int right;
    logic [1:0] d;
    logic found;
    age_t oldest;
    r = '0;
    found = 1'b0;
    oldest = '0;
    s = port * NUM_VCS + vc;
    if (req == REQ_LOAD && port < NUM_PORTS && vc < NUM_VCS) begin
      slot_valid[s] = 1'b1;
      slot_head[s] = head;
      slot_dest[s] = dst;
      slot_age[s] = stamp;
      slot_routed[s] = 1'b0;
      if (head && rdy && !fixed) begin
        d = (dir == DIR_UNUSED) ? DIR_NONE : dir;
        if (dst == router_id) begin
          r.route_port = PORT_LOCAL;
          r.new_dir = d;
        end else if (d != DIR_NONE) begin
          r.route_port = d;
          r.new_dir = d;
        end else begin
          if (int'(router_id) > int'(dst)) begin
            left = int'(router_id) - int'(dst);
            right = int'(dst) - int'(router_id) + int'(ring_size);
          end else begin
            left = int'(router_id) - int'(dst) + int'(ring_size);
            right = int'(dst) - int'(router_id);
          end
          r.route_port = (left < right) ? PORT_LEFT : PORT_RIGHT;
          r.new_dir = r.route_port;
        end
        r.route_done = 1'b1;
        slot_mask[s] = 3'b001 << r.route_port;
        slot_routed[s] = 1'b1;
      end
    end else if (req == REQ_CLEAR && port < NUM_PORTS && vc < NUM_VCS) begin
      slot_valid[s] = 1'b0;
      slot_head[s] = 1'b0;
      slot_routed[s] = 1'b0;
      slot_mask[s] = '0;
    end else if (req == REQ_ARB && op < NUM_PORTS) begin
      for (int p = 0; p < NUM_PORTS; p++) begin
        if (p == op) continue;
        for (int v = 0; v < NUM_VCS; v++) begin
          i = p * NUM_VCS + v;
          if (!slot_valid[i] || !slot_mask[i][op]) continue;
          if (ov == NUM_VCS - 2 && router_id > slot_dest[i]) continue;
          if (ov == NUM_VCS - 1 && router_id < slot_dest[i]) continue;
          if (slot_head[i] && slot_routed[i] && (!found || slot_age[i] < oldest)) begin
            found = 1'b1;
            oldest = slot_age[i];
            r.winner_port = 2'(p);
            r.winner_vc = 2'(v);
          end
        end
      end
      r.winner_found = found;
    end
    return r;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s expected %0d got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    reply_t want;
    if (!rst_n) begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
        slot_valid[k] = 1'b0;
        slot_head[k] = 1'b0;
        slot_routed[k] = 1'b0;
        slot_mask[k] = '0;
        slot_dest[k] = '0;
        slot_age[k] = '0;
      end
      router_id = ROUTER_ID_RST;
      ring_size = RING_SIZE_RST;
      mismatch_count = 0;
      awaited_replies.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr)
          ADDR_ROUTER_ID: router_id = cfg_pwdata[5:0];
          ADDR_RING_SIZE: ring_size = cfg_pwdata[6:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (awaited_replies.size() == 0) begin
          $error("result transfer with no request outstanding");
          mismatch_count++;
        end else begin
          want = awaited_replies.pop_front();
          check_field("route_done", want.route_done, out_route_done);
          check_field("route_port", want.route_port, out_route_port);
          check_field("new_dir", want.new_dir, out_new_dir);
          check_field("winner_found", want.winner_found, out_winner_found);
          check_field("winner_port", want.winner_port, out_winner_port);
          check_field("winner_vc", want.winner_vc, out_winner_vc);
        end
      end
      if (in_valid && in_ready) begin
        awaited_replies.insert(awaited_replies.size(), serve_request(in_req_type,
          in_in_port, in_in_vc, in_flit_dst, in_flit_dir, in_flit_time, in_is_head,
          in_flit_ready, in_route_fixed, in_out_port, in_out_vc));
      end
    end
    replies_due = awaited_replies.size();
  end

endmodule

FILE: tb/tb_ring_router_route_and_vc_alloc.sv
module tb_ring_router_route_and_vc_alloc
  import rrva_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_VCS = 4;
  localparam int PHASES = 7;
  localparam int ITEMS_PER_PHASE = 175;
  localparam int SETTLE = 3 * NUM_VCS + 8;
  localparam int HOLD_CYCLES = 400;
  localparam int LIMIT = 500000;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam age_t AGE_MAX = '1;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_req_type;
  logic [1:0]  in_in_port;
  logic [1:0]  in_in_vc;
  logic [5:0]  in_flit_dst;
  logic [1:0]  in_flit_dir;
  logic [47:0] in_flit_time;
  logic        in_is_head;
  logic        in_flit_ready;
  logic        in_route_fixed;
  logic [1:0]  in_out_port;
  logic [1:0]  in_out_vc;
  logic        out_valid;
  logic        out_ready;
  logic        out_route_done;
  logic [1:0]  out_route_port;
  logic [1:0]  out_new_dir;
  logic        out_winner_found;
  logic [1:0]  out_winner_port;
  logic [1:0]  out_winner_vc;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          mismatch_count;
  int          replies_due;
  int          cycle_count = 0;
  int          hold_reqs = 0;
  bit          steady = 1'b0;
  logic [5:0]  router_id_now;

  ring_router_route_and_vc_alloc #(.NUM_VCS(NUM_VCS)) DUT (.*);

  route_alloc_monitor #(.NUM_VCS(NUM_VCS)) u_monitor (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT) begin
      $display("tb_ring_router_route_and_vc_alloc failed");
      $finish;
    end
  end

  // The receiver stalls at random outside the steady phase; on request it holds off for a long stretch.
  initial begin
    int served;
    served = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != served) begin
        served++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= steady || ($urandom_range(99) >= 29);
    end
  end

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic offer(logic [1:0] req, logic [1:0] port, logic [1:0] vc, logic [5:0] dst,
                       logic [1:0] dir, age_t stamp, logic head, logic rdy, logic fixed,
                       logic [1:0] op, logic [1:0] ov);
    while (!steady && $urandom_range(99) < 29) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_req_type <= req;
    in_in_port <= port;
    in_in_vc <= vc;
    in_flit_dst <= dst;
    in_flit_dir <= dir;
    in_flit_time <= stamp;
    in_is_head <= head;
    in_flit_ready <= rdy;
    in_route_fixed <= fixed;
    in_out_port <= op;
    in_out_vc <= ov;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic load(logic [1:0] port, logic [1:0] vc, logic [5:0] dst, logic [1:0] dir,
                      age_t stamp, logic head, logic rdy, logic fixed);
    offer(REQ_LOAD, port, vc, dst, dir, stamp, head, rdy, fixed, PORT_LOCAL, 2'd0);
  endtask

  task automatic arbitrate(logic [1:0] op, logic [1:0] ov);
    offer(REQ_ARB, PORT_LOCAL, 2'd0, 6'd0, DIR_NONE, '0, 1'b0, 1'b0, 1'b0, op, ov);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (replies_due != 0) @(negedge clk);
  endtask

  task automatic offer_random();
    logic [1:0] req;
    logic [1:0] port;
    logic [1:0] dir;
    logic [1:0] op;
    logic [5:0] dst;
    age_t stamp;
    int pick;
    pick = $urandom_range(99);
    if (pick < 48) req = REQ_LOAD;
    else if (pick < 60) req = REQ_CLEAR;
    else if (pick < 96) req = REQ_ARB;
    else req = REQ_UNKNOWN;
    port = ($urandom_range(19) == 0) ? PORT_INVALID : 2'($urandom_range(NUM_PORTS - 1));
    dst = ($urandom_range(3) == 0) ? router_id_now : 6'($urandom_range(63));
    dir = ($urandom_range(2) == 0) ? 2'($urandom_range(3)) : DIR_NONE;
    if ($urandom_range(1) == 0) stamp = age_t'($urandom_range(15));
    else stamp = {16'($urandom()), 32'($urandom())};
    op = ($urandom_range(15) == 0) ? PORT_INVALID : 2'($urandom_range(NUM_PORTS - 1));
    offer(req, port, 2'($urandom_range(NUM_VCS - 1)), dst, dir, stamp,
          $urandom_range(9) != 0, $urandom_range(9) != 0, $urandom_range(9) == 0,
          op, 2'($urandom_range(3)));
  endtask

  // Router 5 on a ring of 8: every routing rule, bad and unknown requests, then arbitration.
  task automatic directed_checks();
    load(PORT_LOCAL, 2'd0, 6'd5, PORT_LEFT, 48'd100, 1'b1, 1'b1, 1'b0);
    load(PORT_LEFT, 2'd0, 6'd7, DIR_NONE, 48'd100, 1'b1, 1'b1, 1'b0);
    load(PORT_RIGHT, 2'd1, 6'd2, DIR_NONE, 48'd50, 1'b1, 1'b1, 1'b0);
    load(PORT_LEFT, 2'd1, 6'd1, DIR_NONE, 48'd100, 1'b1, 1'b1, 1'b0);
    load(PORT_RIGHT, 2'd2, 6'd63, DIR_UNUSED, 48'd50, 1'b1, 1'b1, 1'b0);
    load(PORT_LOCAL, 2'd1, 6'd0, PORT_RIGHT, 48'd100, 1'b1, 1'b1, 1'b0);
    load(PORT_LOCAL, 2'd2, 6'd9, DIR_NONE, 48'd1, 1'b0, 1'b1, 1'b0);
    load(PORT_LOCAL, 2'd3, 6'd9, DIR_NONE, 48'd1, 1'b1, 1'b0, 1'b0);
    load(PORT_LEFT, 2'd2, 6'd9, DIR_NONE, 48'd1, 1'b1, 1'b1, 1'b1);
    load(PORT_INVALID, 2'd0, 6'd9, DIR_NONE, 48'd1, 1'b1, 1'b1, 1'b0);
    offer(REQ_CLEAR, PORT_INVALID, 2'd0, 6'd0, DIR_NONE, '0, 1'b1, 1'b1, 1'b0,
          PORT_LOCAL, 2'd0);
    offer(REQ_UNKNOWN, PORT_LEFT, 2'd1, 6'd63, DIR_NONE, AGE_MAX, 1'b1, 1'b1, 1'b0,
          PORT_RIGHT, 2'd3);
    load(PORT_LEFT, 2'd3, 6'd6, DIR_NONE, 48'd0, 1'b1, 1'b1, 1'b0);
    load(PORT_RIGHT, 2'd3, 6'd4, DIR_NONE, AGE_MAX, 1'b1, 1'b1, 1'b0);
    arbitrate(PORT_RIGHT, 2'd0);
    arbitrate(PORT_RIGHT, 2'(NUM_VCS - 2));
    arbitrate(PORT_RIGHT, 2'(NUM_VCS - 1));
    arbitrate(PORT_LEFT, 2'd1);
    arbitrate(PORT_LOCAL, 2'd0);
    arbitrate(PORT_INVALID, 2'd0);
    offer(REQ_CLEAR, PORT_LEFT, 2'd3, 6'd0, DIR_NONE, '0, 1'b0, 1'b0, 1'b0,
          PORT_LOCAL, 2'd0);
    arbitrate(PORT_RIGHT, 2'd0);
    load(PORT_RIGHT, 2'd1, 6'd2, DIR_NONE, 48'd50, 1'b1, 1'b0, 1'b0);
    arbitrate(PORT_LEFT, 2'd1);
  endtask

  initial begin
    int ph;
    int k;
    logic [6:0] ring_now;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = REQ_LOAD;
    in_in_port = PORT_LOCAL;
    in_in_vc = '0;
    in_flit_dst = '0;
    in_flit_dir = DIR_NONE;
    in_flit_time = '0;
    in_is_head = 1'b0;
    in_flit_ready = 1'b0;
    in_route_fixed = 1'b0;
    in_out_port = PORT_LOCAL;
    in_out_vc = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = ADDR_ROUTER_ID;
    cfg_pwdata = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    for (ph = 0; ph < PHASES; ph++) begin
      drain();
      repeat (SETTLE) @(negedge clk);
      case (ph)
        0: begin router_id_now = 6'd5; ring_now = 7'd8; end
        1: begin router_id_now = 6'd0; ring_now = 7'd2; end
        2: begin router_id_now = 6'd63; ring_now = 7'd64; end
        3: begin router_id_now = 6'd31; ring_now = 7'd64; end
        4: begin router_id_now = 6'd10; ring_now = 7'd11; end
        5: begin router_id_now = 6'd40; ring_now = 7'd7; end
        default: begin
          router_id_now = 6'($urandom_range(63));
          ring_now = 7'($urandom_range(64, 2));
        end
      endcase
      write_reg(ADDR_ROUTER_ID, 32'(router_id_now));
      write_reg(ADDR_RING_SIZE, 32'(ring_now));
      steady = (ph == 3);
      if (ph == 0) directed_checks();
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (ph == 1 && k == 40) hold_reqs++;
        if (ph == 2 && k == 80) drain();
        offer_random();
      end
    end
    drain();
    repeat (SETTLE) @(negedge clk);
    if (mismatch_count == 0 && replies_due == 0) begin
      $display("tb_ring_router_route_and_vc_alloc passed");
    end else begin
      $display("tb_ring_router_route_and_vc_alloc failed");
    end
    $finish;
  end

endmodule
